// File: src/assert_macros.svh
// assertion macros included by the rtl file ssq_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, ignored while reset is held
`define SSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on every rising edge of clk, ignored while reset is held
`define SSQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Types, codes and constants of the stepper speed sequencer.
// ----------------------------------------------------------------------------
package ssq_pkg;

	localparam int PHASE_COUNT = 8;
	localparam int PHASE_W     = $clog2(PHASE_COUNT);
	localparam int SAMPLE_BITS = 10;
	localparam int SAMPLE_W    = 10;
	localparam int GAIN_W      = 8;
	localparam int PERIOD_W    = 16;
	localparam int PROD_W      = GAIN_W + SAMPLE_BITS;
	localparam int PIN_W       = 6;
	localparam int CFG_IDX_W   = 2;

	localparam logic [PIN_W-1:0] GREEN_BIT = 6'b01_0000;
	localparam logic [PIN_W-1:0] RED_BIT   = 6'b10_0000;

	localparam logic [PERIOD_W-1:0] RST_SPEED_OFFSET = 16'd60000;
	localparam logic [GAIN_W-1:0]   RST_SPEED_GAIN   = 8'd55;
	localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD   = 16'd2000;
	localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD   = 16'd60000;
	localparam logic [PERIOD_W-1:0] RST_COMPARE      = 16'd20000;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_SAMPLE = 2'd1,
		MODE_ESTOP  = 2'd2,
		MODE_NONE   = 2'd3
	} ssq_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_OFFSET = 2'd0,
		REG_SPEED_GAIN   = 2'd1,
		REG_MIN_PERIOD   = 2'd2,
		REG_MAX_PERIOD   = 2'd3
	} ssq_reg_t;

	typedef struct packed {
		logic [1:0]          mode;
		logic [SAMPLE_W-1:0] pot_sample;
	} ssq_in_t;

	typedef struct packed {
		logic [PIN_W-1:0]    pin_bits;
		logic                stepped;
		logic                halted;
		logic [PERIOD_W-1:0] period_now;
	} ssq_out_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] speed_offset;
		logic [GAIN_W-1:0]   speed_gain;
		logic [PERIOD_W-1:0] min_period;
		logic [PERIOD_W-1:0] max_period;
	} ssq_cfg_t;

	// item as held in the input register, product already formed
	typedef struct packed {
		ssq_mode_t         mode;
		logic [PROD_W-1:0] product;
	} ssq_item_t;

	// half-step coil sequence
	function automatic logic [PIN_W-1:0] coil_pattern(input logic [PHASE_W-1:0] idx);
		logic [PIN_W-1:0] pat;
		unique case (idx)
			3'd0: pat = 6'b00_1000;
			3'd1: pat = 6'b00_1100;
			3'd2: pat = 6'b00_0100;
			3'd3: pat = 6'b00_0110;
			3'd4: pat = 6'b00_0010;
			3'd5: pat = 6'b00_0011;
			3'd6: pat = 6'b00_0001;
			3'd7: pat = 6'b00_1001;
			default: pat = '0;
		endcase
		return pat;
	endfunction

endpackage

// File: src/stepper_speed_sequencer_core.sv
// ----------------------------------------------------------------------------
// stepper_speed_sequencer_core
// Half-step stepper sequencer with potentiometer speed setting and a latched
// emergency stop.
// ----------------------------------------------------------------------------
// One item (timer tick, potentiometer sample, emergency press or no-op) is
// taken every clock while the input register is free or being emptied, and
// each gives exactly one result: the input register forms gain times sample,
// then a combinational state update (counter compare, coil table lookup,
// period clamp) loads the result register. That state update is the loop
// that sets the rate of one item per cycle when the output does not stall.
// Results wait in the output register under back-pressure while the next
// item is already held at the input. Configuration writes are always taken
// and must only be issued while no item is in flight.
module stepper_speed_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ssq_pkg::ssq_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ssq_pkg::ssq_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssq_pkg::PERIOD_W-1:0]  cfg_data
);
	import ssq_pkg::*;

	ssq_cfg_t  cfg;
	ssq_item_t item;
	logic      item_valid;
	logic      item_take;

	assign cfg_ready = 1'b1;

	ssq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ssq_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.speed_gain (cfg.speed_gain),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	ssq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: src/ssq_cfg.sv
// ----------------------------------------------------------------------------
// ssq_cfg
// Configuration registers: speed offset, gain and the period limits.
// ----------------------------------------------------------------------------
module ssq_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ssq_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [ssq_pkg::PERIOD_W-1:0]    wr_data,
	output ssq_pkg::ssq_cfg_t               cfg
);
	import ssq_pkg::*;

	ssq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_offset <= RST_SPEED_OFFSET;
			cfg_q.speed_gain   <= RST_SPEED_GAIN;
			cfg_q.min_period   <= RST_MIN_PERIOD;
			cfg_q.max_period   <= RST_MAX_PERIOD;
		end else if (wr_en) begin
			unique case (ssq_reg_t'(wr_index))
				REG_SPEED_OFFSET: cfg_q.speed_offset <= wr_data;
				REG_SPEED_GAIN:   cfg_q.speed_gain   <= wr_data[GAIN_W-1:0];
				REG_MIN_PERIOD:   cfg_q.min_period   <= wr_data;
				REG_MAX_PERIOD:   cfg_q.max_period   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/ssq_in_stage.sv
// ----------------------------------------------------------------------------
// ssq_in_stage
// Input register; forms gain times sample so the next stage need not multiply.
// ----------------------------------------------------------------------------
module ssq_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ssq_pkg::ssq_in_t      in_data,
	input  logic [ssq_pkg::GAIN_W-1:0] speed_gain,
	output logic                  item_valid,
	input  logic                  item_take,
	output ssq_pkg::ssq_item_t    item
);
	import ssq_pkg::*;

	logic      valid_s1;
	ssq_item_t item_s1;
	logic      load;

	assign in_ready = !valid_s1 || item_take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (item_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.mode    <= ssq_mode_t'(in_data.mode);
			item_s1.product <= PROD_W'(speed_gain) * PROD_W'(in_data.pot_sample[SAMPLE_BITS-1:0]);
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// File: src/ssq_core.sv
// ----------------------------------------------------------------------------
// ssq_core
// Sequencer state update and result register: tick counter, coil phase,
// speed clamp and the emergency latch.
// ----------------------------------------------------------------------------
module ssq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  ssq_pkg::ssq_cfg_t  cfg,
	input  logic               item_valid,
	output logic               item_take,
	input  ssq_pkg::ssq_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	output ssq_pkg::ssq_out_t  out_data
);
	import ssq_pkg::*;
	`include "assert_macros.svh"

	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic                running_q, running_d;
	logic [PERIOD_W-1:0] count_q, count_d;
	logic [PERIOD_W-1:0] compare_q, compare_d;
	logic [PIN_W-1:0]    pins_q, pins_d;
	logic                stepped_d;
	logic                out_valid_q;
	ssq_out_t            out_q;
	logic [PERIOD_W-1:0] speed_raw, speed_lo;

	assign item_take = item_valid && (!out_valid_q || out_ready);

	// offset minus product, floored and clamped; max wins when limits cross
	always_comb begin
		if (item.product > PROD_W'(cfg.speed_offset)) begin
			speed_raw = cfg.min_period;
		end else begin
			speed_raw = cfg.speed_offset - item.product[PERIOD_W-1:0];
		end
		speed_lo = (speed_raw < cfg.min_period) ? cfg.min_period : speed_raw;
	end

	always_comb begin
		phase_d   = phase_q;
		running_d = running_q;
		count_d   = count_q;
		compare_d = compare_q;
		pins_d    = pins_q;
		stepped_d = 1'b0;
		unique case (item.mode)
			MODE_TICK: begin
				if (count_q == compare_q) begin
					count_d = '0;
					if (running_q) begin
						pins_d    = GREEN_BIT | coil_pattern(phase_q);
						phase_d   = phase_q + 1'b1;
						stepped_d = 1'b1;
					end
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			MODE_SAMPLE: begin
				if (running_q) begin
					compare_d = (speed_lo > cfg.max_period) ? cfg.max_period : speed_lo;
				end
			end
			MODE_ESTOP: begin
				running_d = 1'b0;
				pins_d    = RED_BIT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			running_q   <= 1'b1;
			count_q     <= '0;
			compare_q   <= RST_COMPARE;
			pins_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				phase_q   <= phase_d;
				running_q <= running_d;
				count_q   <= count_d;
				compare_q <= compare_d;
				pins_q    <= pins_d;
			end
			if (item_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			out_q.pin_bits   <= pins_d;
			out_q.stepped    <= stepped_d;
			out_q.halted     <= !running_d;
			out_q.period_now <= compare_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SSQ_ASSERT_IMP(a_stop_latched, !running_q, ##1 !running_q, "emergency stop released without reset")
	`SSQ_ASSERT_IMP(a_halt_red, out_valid_q && out_q.halted, out_q.pin_bits == RED_BIT, "halted result without red-only pins")
	`SSQ_ASSERT_IMP(a_step_green, out_valid_q && out_q.stepped, out_q.pin_bits[4] && !out_q.halted, "step reported without green run bit")
	`SSQ_ASSERT_IMP(a_out_matches_state, out_valid_q, (out_q.halted == !running_q) && (out_q.period_now == compare_q), "result register out of step with state")

endmodule
